>>> sv/gcl_pkg.sv
// Shared types, constants and elaboration-time CORDIC tables for the great-circle block.
`default_nettype none

package gcl_pkg;

  localparam int CORDIC_STAGES   = 32;
  localparam int ANGLE_FRAC_BITS = 30;
  localparam int WORK_BITS       = 60;
  localparam int TABLE_LEN       = 48;
  localparam int LL_FRAC_BITS    = 20;
  localparam int DIST_FRAC_BITS  = 8;
  localparam int STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int Q_SHIFT = WORK_BITS - ANGLE_FRAC_BITS;

  typedef logic signed [63:0] word_t;

  typedef struct packed {
    logic         neg;
    logic [127:0] mag;
  } prod_t;

  localparam logic signed [27:0] LAT_LIMIT   = 28'sd94371840;
  localparam int                 FULL_TURN   = 377487360;
  localparam logic signed [33:0] HALF_TURN   = 34'sd188743680;
  localparam word_t              DIST_MAX    = 64'sd17179869183;
  localparam logic [23:0]        RADIUS_INIT = 24'd6371229;
  localparam word_t              ANG_MIN     = 64'sd1 <<< (WORK_BITS - STAGES);

  // Sign-magnitude product: round half away from zero, shift, saturate.
  function automatic word_t rnd_shift(prod_t p, int unsigned sh);
    logic [127:0] t;
    word_t r;
    t = (p.mag + (128'd1 << (sh - 1))) >> sh;
    if (|t[127:63]) r = 64'sh7fff_ffff_ffff_ffff;
    else r = word_t'(t[63:0]);
    return p.neg ? -r : r;
  endfunction

  function automatic word_t mulq_c(word_t a, word_t b);
    logic [63:0] ua;
    logic [63:0] ub;
    prod_t p;
    ua = a[63] ? (~a + 64'd1) : a;
    ub = b[63] ? (~b + 64'd1) : b;
    p.neg = a[63] ^ b[63];
    p.mag = {64'd0, ua} * {64'd0, ub};
    return rnd_shift(p, WORK_BITS);
  endfunction

  // atan(1) by Machin: 4*atan(1/5) - atan(1/239), series with truncating terms.
  function automatic word_t machin();
    logic [63:0] p5;
    logic [63:0] s5;
    logic [63:0] p239;
    logic [63:0] s239;
    p5 = (64'd1 << WORK_BITS) / 5;
    s5 = '0;
    p239 = (64'd1 << WORK_BITS) / 239;
    s239 = '0;
    for (int k = 0; k < 40; k++) begin
      if (p5 != 64'd0) begin
        if (k[0]) s5 = s5 - p5 / 64'(2 * k + 1);
        else s5 = s5 + p5 / 64'(2 * k + 1);
        p5 = p5 / 25;
      end
      if (p239 != 64'd0) begin
        if (k[0]) s239 = s239 - p239 / 64'(2 * k + 1);
        else s239 = s239 + p239 / 64'(2 * k + 1);
        p239 = p239 / 57121;
      end
    end
    return word_t'(64'd4 * s5 - s239);
  endfunction

  function automatic word_t atan_pow2(int i);
    logic [63:0] s;
    logic [63:0] t;
    int e;
    s = '0;
    for (int k = 0; k < 64; k++) begin
      e = WORK_BITS - i * (2 * k + 1);
      if (e >= 0) begin
        t = (64'd1 << e) / 64'(2 * k + 1);
        if (k[0]) s = s - t;
        else s = s + t;
      end
    end
    return word_t'(s);
  endfunction

  function automatic word_t atan_entry(int i);
    return (i == 0) ? machin() : atan_pow2(i);
  endfunction

  function automatic word_t calc_gg();
    word_t gg;
    gg = 64'sd1 <<< WORK_BITS;
    for (int i = 0; i < STAGES; i++) begin
      if (2 * i < WORK_BITS + 1) gg = gg + (gg >>> (2 * i));
    end
    return gg;
  endfunction

  // Gain correction by Newton steps on 1/sqrt(gg).
  function automatic word_t calc_k();
    word_t gg;
    word_t y;
    gg = calc_gg();
    y = (64'sd3 <<< WORK_BITS) / 5;
    for (int i = 0; i < 8; i++) begin
      y = mulq_c(y, (64'sd3 <<< WORK_BITS) - mulq_c(gg, mulq_c(y, y))) >>> 1;
    end
    return y;
  endfunction

  localparam word_t PI_W      = 4 * atan_entry(0);
  localparam word_t HALF_PI_W = 2 * atan_entry(0);
  localparam word_t DEG_W     = (PI_W + 90) / 180;
  localparam word_t K_W       = calc_k();
  localparam word_t G_W       = mulq_c(calc_gg(), calc_k());

endpackage

`default_nettype wire

>>> sv/gcl_mul.sv
// Two-stage sign-magnitude 64x64 multiplier built from four 32x32 partial products.
`default_nettype none

module gcl_mul (
  input  logic           clk,
  input  logic           en,
  input  gcl_pkg::word_t a,
  input  gcl_pkg::word_t b,
  output gcl_pkg::prod_t p
);
  import gcl_pkg::*;

  logic [63:0] ua;
  logic [63:0] ub;
  logic [63:0] ll_r;
  logic [63:0] lh_r;
  logic [63:0] hl_r;
  logic [63:0] hh_r;
  logic        neg_r;
  prod_t       p_r;

  always_comb begin
    ua = a[63] ? (~a + 64'd1) : a;
    ub = b[63] ? (~b + 64'd1) : b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= {32'd0, ua[31:0]} * {32'd0, ub[31:0]};
      lh_r  <= {32'd0, ua[31:0]} * {32'd0, ub[63:32]};
      hl_r  <= {32'd0, ua[63:32]} * {32'd0, ub[31:0]};
      hh_r  <= {32'd0, ua[63:32]} * {32'd0, ub[63:32]};
      neg_r <= a[63] ^ b[63];
      p_r.mag <= {64'd0, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0}
                 + {hh_r, 64'd0};
      p_r.neg <= neg_r;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

>>> sv/gcl_rot.sv
// Pipelined rotation-mode CORDIC: one micro-rotation per register stage, yields cos and sin.
`default_nettype none

module gcl_rot (
  input  logic           clk,
  input  logic           en,
  input  gcl_pkg::word_t z_in,
  output gcl_pkg::word_t c_out,
  output gcl_pkg::word_t s_out
);
  import gcl_pkg::*;

  word_t x_r [STAGES];
  word_t y_r [STAGES];
  word_t z_r [STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam word_t ANG = atan_entry(i);
    word_t xp;
    word_t yp;
    word_t zp;

    if (i == 0) begin : g_head
      assign xp = K_W;
      assign yp = '0;
      assign zp = z_in;
    end else begin : g_body
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zp[63]) begin
          x_r[i] <= xp - (yp >>> i);
          y_r[i] <= yp + (xp >>> i);
        end else begin
          x_r[i] <= xp + (yp >>> i);
          y_r[i] <= yp - (xp >>> i);
        end
      end
    end

    if (i < STAGES - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[i] <= zp[63] ? (zp + ANG) : (zp - ANG);
        end
      end
    end
  end

  assign c_out = x_r[STAGES-1];
  assign s_out = y_r[STAGES-1];

endmodule

`default_nettype wire

>>> sv/gcl_vec.sv
// Pipelined vectoring-mode CORDIC: drives y toward zero, accumulates the angle.
`default_nettype none

module gcl_vec (
  input  logic           clk,
  input  logic           en,
  input  gcl_pkg::word_t x_in,
  input  gcl_pkg::word_t y_in,
  output gcl_pkg::word_t x_out,
  output gcl_pkg::word_t z_out
);
  import gcl_pkg::*;

  word_t x_r [STAGES];
  word_t y_r [STAGES-1];
  word_t z_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam word_t ANG = atan_entry(i);
    word_t xp;
    word_t yp;
    word_t zp;

    if (i == 0) begin : g_head
      assign xp = x_in;
      assign yp = y_in;
      assign zp = '0;
    end else begin : g_body
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!yp[63]) begin
          x_r[i] <= xp + (yp >>> i);
          z_r[i] <= zp + ANG;
        end else begin
          x_r[i] <= xp - (yp >>> i);
          z_r[i] <= zp - ANG;
        end
      end
    end

    if (i < STAGES - 1) begin : g_y
      always_ff @(posedge clk) begin
        if (en) begin
          y_r[i] <= yp[63] ? (yp + (xp >>> i)) : (yp - (xp >>> i));
        end
      end
    end
  end

  assign x_out = x_r[STAGES-1];
  assign z_out = z_r[STAGES-1];

endmodule

`default_nettype wire

>>> sv/great_circle_latlon_distance.sv
// Great-circle central angle and distance between two lat/lon points (Vincenty atan2 form).
// Throughput: one point pair per cycle while the skid is empty; a stall loses no beat.
// Datapath: three chained CORDIC pipelines (sin/cos, root, atan2) and multiplier stages.
// Reset: synchronous active-low; clears all valid bits and loads the radius register.
`default_nettype none

module great_circle_latlon_distance (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [27:0] in_first_lat,
  input  logic signed [29:0] in_first_lon,
  input  logic signed [27:0] in_second_lat,
  input  logic signed [29:0] in_second_lon,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_central_angle,
  output logic [33:0]        out_distance,
  output logic               out_range_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data
);
  import gcl_pkg::*;

  localparam int LAST  = 3 * STAGES + 17;
  localparam int CDLY  = STAGES - 3;

  logic        adv;
  logic [23:0] radius_r;
  logic [LAST-1:0] v_r;

  // stage 1: input capture
  logic signed [27:0] lat1_s1, lat2_s1;
  logic signed [29:0] lon1_s1, lon2_s1;
  // stage 2: range check, longitude wrap
  logic signed [33:0] dlon, cand, dwrap;
  logic signed [27:0] lat1_s2, lat2_s2;
  logic [27:0]        dl_s2;
  logic               err_s2;
  prod_t pz1, pz2, pzl;
  word_t z1_s5, z2_s5, zl_s5, z1_s6, z2_s6, zl_s6;
  logic  neg_s6;
  logic  negd_r [STAGES];
  word_t c1, s1, c2, s2, cl, sl;
  word_t cln_s39, cln_s40, cln_s41;
  prod_t pa, pt, pp1, pp2, pp3, ptc, pp3c;
  word_t a_s41, t_s41, p1_s41, p2_s41, p3_s41;
  word_t a_s42, a_s43, a_s44, p1_s42, p1_s43, p1_s44, p2_s42, p2_s43, p2_s44;
  word_t tcl_s44, p3cl_s44;
  word_t aa_s45, b_s45, c_s45;
  word_t mag;
  word_t cdly_r [CDLY];
  prod_t pcx;
  word_t cx_s77;
  word_t x0_s78, y0_s78, off_s78;
  logic  zero_s78;
  word_t offd_r [STAGES];
  logic  zerod_r [STAGES];
  word_t zz, ang_sum;
  word_t ang_s111;
  prod_t pd;
  logic [63:0] qsum, qshift;
  logic [31:0] q_s112, q_s113;
  logic  errd_r [LAST-2];
  word_t dist_w;
  logic [33:0] dist_fin;
  logic        pipe_item;

  logic        out_valid_r, skid_valid_r;
  logic [31:0] out_central_angle_r, skid_angle_r, angle_fin;
  logic [33:0] out_distance_r, skid_dist_r, dist_out;
  logic        out_range_error_r, skid_err_r, err_fin;

  assign adv       = !skid_valid_r;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_INIT;
      v_r      <= '0;
    end else begin
      if (cfg_valid) radius_r <= cfg_data;
      if (adv) v_r <= {v_r[LAST-2:0], in_valid};
    end
  end

  always_comb begin
    dlon = 34'(lon2_s1) - 34'(lon1_s1);
  end

  // pick the lap offset that lands the difference in (-180, 180]
  always_comb begin
    dwrap = '0;
    cand  = '0;
    for (int k = -3; k <= 3; k++) begin
      cand = dlon + 34'(k * FULL_TURN);
      if (cand > -HALF_TURN && cand <= HALF_TURN) dwrap = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat1_s1 <= in_first_lat;
      lon1_s1 <= in_first_lon;
      lat2_s1 <= in_second_lat;
      lon2_s1 <= in_second_lon;
      lat1_s2 <= lat1_s1;
      lat2_s2 <= lat2_s1;
      dl_s2   <= dwrap[33] ? 28'(-dwrap) : dwrap[27:0];
      err_s2  <= lat1_s1 > LAT_LIMIT || lat1_s1 < -LAT_LIMIT
                 || lat2_s1 > LAT_LIMIT || lat2_s1 < -LAT_LIMIT;
    end
  end

  gcl_mul u_mz1 (.clk, .en(adv), .a(word_t'(lat1_s2)), .b(DEG_W), .p(pz1));
  gcl_mul u_mz2 (.clk, .en(adv), .a(word_t'(lat2_s2)), .b(DEG_W), .p(pz2));
  gcl_mul u_mzl (.clk, .en(adv), .a(word_t'({36'd0, dl_s2})), .b(DEG_W), .p(pzl));

  // fold the longitude angle past 90 degrees, flip cos later
  always_ff @(posedge clk) begin
    if (adv) begin
      z1_s5 <= rnd_shift(pz1, LL_FRAC_BITS);
      z2_s5 <= rnd_shift(pz2, LL_FRAC_BITS);
      zl_s5 <= rnd_shift(pzl, LL_FRAC_BITS);
      z1_s6 <= z1_s5;
      z2_s6 <= z2_s5;
      if (zl_s5 > HALF_PI_W) begin
        zl_s6  <= PI_W - zl_s5;
        neg_s6 <= 1'b1;
      end else begin
        zl_s6  <= zl_s5;
        neg_s6 <= 1'b0;
      end
    end
  end

  gcl_rot u_rot1 (.clk, .en(adv), .z_in(z1_s6), .c_out(c1), .s_out(s1));
  gcl_rot u_rot2 (.clk, .en(adv), .z_in(z2_s6), .c_out(c2), .s_out(s2));
  gcl_rot u_rotl (.clk, .en(adv), .z_in(zl_s6), .c_out(cl), .s_out(sl));

  always_ff @(posedge clk) begin
    if (adv) begin
      negd_r[0] <= neg_s6;
      for (int k = 1; k < STAGES; k++) negd_r[k] <= negd_r[k-1];
      cln_s39 <= negd_r[STAGES-1] ? -cl : cl;
      cln_s40 <= cln_s39;
      cln_s41 <= cln_s40;
    end
  end

  gcl_mul u_ma (.clk, .en(adv), .a(c2), .b(sl), .p(pa));
  gcl_mul u_mt (.clk, .en(adv), .a(s1), .b(c2), .p(pt));
  gcl_mul u_m1 (.clk, .en(adv), .a(c1), .b(s2), .p(pp1));
  gcl_mul u_m2 (.clk, .en(adv), .a(s1), .b(s2), .p(pp2));
  gcl_mul u_m3 (.clk, .en(adv), .a(c1), .b(c2), .p(pp3));

  always_ff @(posedge clk) begin
    if (adv) begin
      a_s41  <= rnd_shift(pa, WORK_BITS);
      t_s41  <= rnd_shift(pt, WORK_BITS);
      p1_s41 <= rnd_shift(pp1, WORK_BITS);
      p2_s41 <= rnd_shift(pp2, WORK_BITS);
      p3_s41 <= rnd_shift(pp3, WORK_BITS);
    end
  end

  gcl_mul u_mtc  (.clk, .en(adv), .a(t_s41), .b(cln_s41), .p(ptc));
  gcl_mul u_mp3c (.clk, .en(adv), .a(p3_s41), .b(cln_s41), .p(pp3c));

  always_ff @(posedge clk) begin
    if (adv) begin
      a_s42  <= a_s41;
      a_s43  <= a_s42;
      a_s44  <= a_s43;
      p1_s42 <= p1_s41;
      p1_s43 <= p1_s42;
      p1_s44 <= p1_s43;
      p2_s42 <= p2_s41;
      p2_s43 <= p2_s42;
      p2_s44 <= p2_s43;
      tcl_s44  <= rnd_shift(ptc, WORK_BITS);
      p3cl_s44 <= rnd_shift(pp3c, WORK_BITS);
      aa_s45 <= a_s44[63] ? -a_s44 : a_s44;
      b_s45  <= p1_s44 - tcl_s44;
      c_s45  <= p2_s44 + p3cl_s44;
    end
  end

  gcl_vec u_vroot (.clk, .en(adv), .x_in(aa_s45), .y_in(b_s45), .x_out(mag), .z_out());

  // hold the denominator so its gain-scaled copy lands beside the root
  always_ff @(posedge clk) begin
    if (adv) begin
      cdly_r[0] <= c_s45;
      for (int k = 1; k < CDLY; k++) cdly_r[k] <= cdly_r[k-1];
    end
  end

  gcl_mul u_mcx (.clk, .en(adv), .a(cdly_r[CDLY-1]), .b(G_W), .p(pcx));

  // negative denominator: turn by 90 degrees before vectoring
  always_ff @(posedge clk) begin
    if (adv) begin
      cx_s77   <= rnd_shift(pcx, WORK_BITS);
      zero_s78 <= (cx_s77 == '0) && (mag == '0);
      if (cx_s77[63]) begin
        x0_s78  <= mag;
        y0_s78  <= -cx_s77;
        off_s78 <= HALF_PI_W;
      end else begin
        x0_s78  <= cx_s77;
        y0_s78  <= mag;
        off_s78 <= '0;
      end
    end
  end

  gcl_vec u_vatan (.clk, .en(adv), .x_in(x0_s78), .y_in(y0_s78), .x_out(), .z_out(zz));

  assign ang_sum = offd_r[STAGES-1] + zz;

  always_ff @(posedge clk) begin
    if (adv) begin
      offd_r[0]  <= off_s78;
      zerod_r[0] <= zero_s78;
      for (int k = 1; k < STAGES; k++) begin
        offd_r[k]  <= offd_r[k-1];
        zerod_r[k] <= zerod_r[k-1];
      end
      ang_s111 <= (zerod_r[STAGES-1] || ang_sum < ANG_MIN) ? '0 : ang_sum;
    end
  end

  gcl_mul u_mdist (.clk, .en(adv), .a(ang_s111), .b(word_t'({40'd0, radius_r})), .p(pd));

  always_comb begin
    qsum   = 64'(ang_s111) + (64'd1 << (Q_SHIFT - 1));
    qshift = qsum >> Q_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_s112 <= (|qshift[63:32]) ? '1 : qshift[31:0];
      q_s113 <= q_s112;
      errd_r[0] <= err_s2;
      for (int k = 1; k < LAST - 2; k++) errd_r[k] <= errd_r[k-1];
    end
  end

  always_comb begin
    dist_w    = rnd_shift(pd, WORK_BITS - DIST_FRAC_BITS);
    dist_fin  = (dist_w > DIST_MAX) ? DIST_MAX[33:0] : dist_w[33:0];
    err_fin   = errd_r[LAST-3];
    angle_fin = err_fin ? '0 : q_s113;
    dist_out  = err_fin ? '0 : dist_fin;
    pipe_item = v_r[LAST-1] && adv;
  end

  // output register plus skid: drain skid first, park a beat there on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (pipe_item) begin
      if (!out_valid_r || out_ready) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_central_angle_r <= skid_angle_r;
        out_distance_r      <= skid_dist_r;
        out_range_error_r   <= skid_err_r;
      end
    end else if (pipe_item) begin
      if (!out_valid_r || out_ready) begin
        out_central_angle_r <= angle_fin;
        out_distance_r      <= dist_out;
        out_range_error_r   <= err_fin;
      end else begin
        skid_angle_r <= angle_fin;
        skid_dist_r  <= dist_out;
        skid_err_r   <= err_fin;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_central_angle = out_central_angle_r;
  assign out_distance      = out_distance_r;
  assign out_range_error   = out_range_error_r;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid filled without an output stall");

  a_err_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_range_error_r |-> out_central_angle_r == '0 && out_distance_r == '0)
    else $error("range error beat carries nonzero angle or distance");
`endif

endmodule

`default_nettype wire

>>> tb/great_circle_latlon_distance_test.sv
// Self-checking testbench for the great-circle angle and distance block.
`default_nettype none

module great_circle_latlon_distance_test;

  localparam int     N_STAGES   = 32;
  localparam int     FRAC_Q     = 60;
  localparam int     ANGLE_BITS = 30;
  localparam longint LAT_LIM    = 94371840;
  localparam longint TURN       = 377487360;
  localparam longint HALF_TURN  = 188743680;
  localparam longint DIST_SAT   = 64'd17179869183;
  localparam longint ANGLE_SAT  = 64'd4294967295;
  localparam int     DRAIN_WAIT = 140;
  localparam int     LONG_HOLD  = 400;

  typedef struct packed {
    logic signed [27:0] lat_a;
    logic signed [29:0] lon_a;
    logic signed [27:0] lat_b;
    logic signed [29:0] lon_b;
  } point_pair_t;

  typedef struct packed {
    logic [31:0] angle;
    logic [33:0] arc_len;
    logic        lat_err;
  } arc_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [27:0] in_first_lat = '0;
  logic signed [29:0] in_first_lon = '0;
  logic signed [27:0] in_second_lat = '0;
  logic signed [29:0] in_second_lon = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [31:0]        out_central_angle;
  logic [33:0]        out_distance;
  logic               out_range_error;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [23:0]        cfg_data = '0;

  longint      atan_tab [0:47];
  longint      pi_q, half_pi_q, deg_q, gain_inv_q, gain_q;
  logic [23:0] radius_now = 24'd6371229;

  point_pair_t pending_pairs[$];
  arc_t        arcs_due[$];
  int          mismatches = 0;
  bit          no_idle = 1'b0;
  bit          long_hold_tog = 1'b0;
  bit          long_hold_seen = 1'b0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          rx_hold_left = 0;

  great_circle_latlon_distance u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_lat(in_first_lat), .in_first_lon(in_first_lon),
    .in_second_lat(in_second_lat), .in_second_lon(in_second_lon),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_central_angle(out_central_angle), .out_distance(out_distance),
    .out_range_error(out_range_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sign-magnitude multiply, round half away from zero, shift by s, saturate.
  function automatic longint mul_round(longint a, longint b, int s);
    logic [63:0]  ua, ub, r;
    logic [127:0] p;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (s - 1))) >> s;
    r = (|p[127:63]) ? 64'h7fff_ffff_ffff_ffff : p[63:0];
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint atan_inv(logic [63:0] n);
    logic [63:0] p, n2, sum, t;
    int k;
    p = (64'd1 << FRAC_Q) / n;
    n2 = n * n;
    sum = '0;
    k = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      if (k[0]) sum = sum - t;
      else sum = sum + t;
      p = p / n2;
      k++;
    end
    return longint'(sum);
  endfunction

  function automatic longint atan_shift(int i);
    logic [63:0] sum, t;
    int e;
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      e = FRAC_Q - i * (2 * k + 1);
      if (e >= 0) begin
        t = (64'd1 << e) / (2 * k + 1);
        if (k[0]) sum = sum - t;
        else sum = sum + t;
      end
    end
    return longint'(sum);
  endfunction

  function automatic void build_cordic_consts();
    longint gg, y;
    gg = longint'(1) <<< FRAC_Q;
    y = (longint'(3) <<< FRAC_Q) / 5;
    atan_tab[0] = 4 * atan_inv(5) - atan_inv(239);
    for (int i = 1; i < 48; i++) atan_tab[i] = atan_shift(i);
    pi_q = 4 * atan_tab[0];
    half_pi_q = 2 * atan_tab[0];
    deg_q = (pi_q + 90) / 180;
    for (int i = 0; i < N_STAGES; i++)
      if (2 * i < FRAC_Q + 1) gg = gg + (gg >>> (2 * i));
    for (int i = 0; i < 8; i++)
      y = mul_round(y, (longint'(3) <<< FRAC_Q) -
                    mul_round(gg, mul_round(y, y, FRAC_Q), FRAC_Q), FRAC_Q) >>> 1;
    gain_inv_q = y;
    gain_q = mul_round(gg, y, FRAC_Q);
  endfunction

  function automatic void cordic_sincos(longint z, output longint c, output longint s);
    longint x, y, xs, ys;
    x = gain_inv_q;
    y = 0;
    for (int i = 0; i < N_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_tab[i];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_tab[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint cordic_vec(longint x, longint y, output longint ang);
    longint xs, ys;
    ang = 0;
    for (int i = 0; i < N_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; ang = ang + atan_tab[i];
      end else begin
        x = x - ys; y = y + xs; ang = ang - atan_tab[i];
      end
    end
    return x;
  endfunction

  function automatic arc_t predict_arc(point_pair_t pp, logic [23:0] radius);
    arc_t   r;
    longint lat1, lat2, dl, lam, c1, s1, c2, s2, cl, sl, a, b, c, t;
    longint mag, cx, ang, zz, arc_len;
    logic [63:0] q;
    lat1 = pp.lat_a;
    lat2 = pp.lat_b;
    r = '0;
    if (lat1 > LAT_LIM || lat1 < -LAT_LIM || lat2 > LAT_LIM || lat2 < -LAT_LIM) begin
      r.lat_err = 1'b1;
      return r;
    end
    dl = (longint'(pp.lon_b) - longint'(pp.lon_a)) % TURN;
    if (dl < 0) dl = dl + TURN;
    if (dl > HALF_TURN) dl = dl - TURN;
    if (dl < 0) dl = -dl;
    cordic_sincos(mul_round(lat1, deg_q, 20), c1, s1);
    cordic_sincos(mul_round(lat2, deg_q, 20), c2, s2);
    lam = mul_round(dl, deg_q, 20);
    // fold past a right angle, cosine flips sign
    if (lam > half_pi_q) begin
      cordic_sincos(pi_q - lam, cl, sl);
      cl = -cl;
    end else begin
      cordic_sincos(lam, cl, sl);
    end
    a = mul_round(c2, sl, FRAC_Q);
    t = mul_round(s1, c2, FRAC_Q);
    b = mul_round(c1, s2, FRAC_Q) - mul_round(t, cl, FRAC_Q);
    c = mul_round(s1, s2, FRAC_Q) +
        mul_round(mul_round(c1, c2, FRAC_Q), cl, FRAC_Q);
    if (a < 0) a = -a;
    mag = cordic_vec(a, b, zz);
    cx = mul_round(c, gain_q, FRAC_Q);
    if (cx == 0 && mag == 0) begin
      ang = 0;
    end else if (cx < 0) begin
      void'(cordic_vec(mag, -cx, zz));
      ang = half_pi_q + zz;
    end else begin
      void'(cordic_vec(cx, mag, zz));
      ang = zz;
    end
    if (ang < (longint'(1) <<< (FRAC_Q - N_STAGES))) ang = 0;
    q = (64'(ang) + (64'd1 << (FRAC_Q - ANGLE_BITS - 1))) >> (FRAC_Q - ANGLE_BITS);
    if (q > ANGLE_SAT) q = ANGLE_SAT;
    arc_len = mul_round(ang, longint'({40'd0, radius}), FRAC_Q - 8);
    if (64'(arc_len) > DIST_SAT) arc_len = DIST_SAT;
    r.angle = q[31:0];
    r.arc_len = arc_len[33:0];
    return r;
  endfunction

  // Sender: hold the beat until accepted, then load the next one or idle.
  always @(posedge clk) begin
    point_pair_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        arcs_due.push_back(predict_arc({in_first_lat, in_first_lon,
                                        in_second_lat, in_second_lon}, radius_now));
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          nxt = pending_pairs.pop_front();
          in_first_lat <= nxt.lat_a;
          in_first_lon <= nxt.lon_a;
          in_second_lat <= nxt.lat_b;
          in_second_lon <= nxt.lon_b;
          in_valid <= 1'b1;
          if (!no_idle && $urandom_range(0, 11) == 0) tx_gap = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure, including the long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (long_hold_tog != long_hold_seen) begin
        long_hold_seen = long_hold_tog;
        rx_hold_left = LONG_HOLD;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 11) == 0) rx_gap = $urandom_range(1, 18);
      end
    end
  end

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    arc_t want;
    if (rst_n && out_valid && out_ready) begin
      if (arcs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: angle=%0d dist=%0d err=%0b",
                   out_central_angle, out_distance, out_range_error);
      end else begin
        want = arcs_due.pop_front();
        if (want.angle !== out_central_angle || want.arc_len !== out_distance ||
            want.lat_err !== out_range_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: angle exp=%0d got=%0d dist exp=%0d got=%0d err exp=%0b got=%0b",
                     want.angle, out_central_angle, want.arc_len, out_distance,
                     want.lat_err, out_range_error);
        end
      end
    end
  end

  task automatic add_pair(longint la, longint oa, longint lb, longint ob);
    point_pair_t pp;
    pp.lat_a = la[27:0];
    pp.lon_a = oa[29:0];
    pp.lat_b = lb[27:0];
    pp.lon_b = ob[29:0];
    pending_pairs.push_back(pp);
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(0, 2 * LAT_LIM)) - LAT_LIM;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(0, 2 * TURN)) - TURN;
  endfunction

  function automatic longint jitter(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic add_random_pairs(int count);
    longint la, oa, lb, ob;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      la = rand_lat();
      oa = rand_lon();
      lb = rand_lat();
      ob = rand_lon();
      if (pick < 60) begin
      end else if (pick < 72) begin
        // nearby points, down to identical ones
        lb = la + jitter($urandom_range(0, 1) ? 4 : 4000);
        ob = oa + jitter($urandom_range(0, 1) ? 4 : 4000);
      end else if (pick < 80) begin
        // close to antipodal
        lb = -la + jitter(3000);
        ob = oa + HALF_TURN + jitter(3000);
      end else if (pick < 92) begin
        // raw bit patterns for longitudes, wraps beyond a full turn
        oa = longint'($signed($urandom() & 32'h3fff_ffff)) <<< 34 >>> 34;
        ob = longint'($signed($urandom() & 32'h3fff_ffff)) <<< 34 >>> 34;
      end else begin
        // raw latitude patterns, partly out of range
        la = longint'($urandom() & 32'h0fff_ffff) <<< 36 >>> 36;
        if (pick[0]) lb = longint'($urandom() & 32'h0fff_ffff) <<< 36 >>> 36;
      end
      add_pair(la, oa, lb, ob);
    end
  endtask

  // sample between edges so the sender's updates at the edge have settled
  task automatic wait_idle();
    while (pending_pairs.size() != 0 || in_valid || arcs_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_radius(logic [23:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    radius_now = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #3000000;
    $display("great_circle_latlon_distance regression: fail");
    $finish;
  end

  initial begin
    build_cordic_consts();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at the reset radius
    add_pair(0, 0, 0, 0);
    add_pair(LAT_LIM, 0, -LAT_LIM, 0);
    add_pair(LAT_LIM, 12345, LAT_LIM, -98765);
    add_pair(0, 0, 0, HALF_TURN);
    add_pair(0, -HALF_TURN, 0, HALF_TURN);
    add_pair(0, -TURN, 0, TURN);
    add_pair(0, 0, 0, HALF_TURN + 1);
    add_pair(0, 0, 0, HALF_TURN - 1);
    add_pair(31457280, 5000, -31457280, 5000 + HALF_TURN);
    add_pair(-LAT_LIM, TURN, LAT_LIM, -TURN);
    add_pair(LAT_LIM + 1, 0, 0, 0);
    add_pair(0, 0, -LAT_LIM - 1, 0);
    add_pair(-134217728, -536870912, 134217727, 536870911);
    add_pair(0, 536870911, 0, -536870912);
    add_pair(1, 0, 0, 0);
    add_pair(0, 0, 0, 1);
    add_pair(47185920, 94371840, 47185921, 94371840);
    add_pair(-62914560, 0, 20971520, 94371840);
    add_pair(41943040, -70000000, 52428800, 2000000);
    wait_idle();

    write_radius(24'hff_ffff);
    add_random_pairs(150);
    wait_idle();

    write_radius(24'd1);
    add_random_pairs(100);
    wait_idle();

    write_radius(24'd0);
    add_pair(0, 0, 0, HALF_TURN);
    add_random_pairs(40);
    wait_idle();

    // fill the pipe behind a stalled receiver
    write_radius(24'($urandom_range(1, 24'hff_ffff)));
    long_hold_tog = ~long_hold_tog;
    add_random_pairs(150);
    wait_idle();

    // sender pauses for a full drain halfway through
    write_radius(24'd6371229);
    add_random_pairs(75);
    wait_idle();
    add_random_pairs(75);
    wait_idle();

    no_idle = 1'b1;
    add_random_pairs(100);
    wait_idle();

    if (mismatches == 0 && arcs_due.size() == 0)
      $display("great_circle_latlon_distance regression: pass");
    else
      $display("great_circle_latlon_distance regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
